@@ hw/rtl/mks_pkg.sv @@
// ----------------------------------------------------------------------------
// mks_pkg: shared types and constants of the matrix keypad scanner
// Field widths, register indexes, scan phases and the structs that pass
// state, configuration and results between the scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mks_pkg;

	// matrix size defaults
	localparam int ROW_COUNT_DEF    = 3;
	localparam int COLUMN_COUNT_DEF = 3;

	// field widths
	localparam int LEVEL_W      = 3;
	localparam int DRIVE_W      = 3;
	localparam int COL_W        = 2;
	localparam int ROW_W        = 2;
	localparam int COUNT_W      = 16;
	localparam int CODE_W       = 8;
	localparam int KEYMAP_LOW_W = 64;
	localparam int POS_W        = 4;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 64;

	// key position held in the separate last-entry register
	localparam logic [POS_W-1:0] POS_LAST = 4'd8;

	// reset value of the debounce length
	localparam logic [COUNT_W-1:0] DEBOUNCE_TICKS_RST = 16'd20;

	typedef enum logic [1:0] {
		PH_SCAN,
		PH_DEBOUNCE,
		PH_RELEASE
	} phase_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_REPORT_MODE,
		REG_DEBOUNCE_TICKS,
		REG_KEYMAP_LOW,
		REG_KEYMAP_LAST
	} cfg_reg_t;

	typedef struct packed {
		logic                    report_mode;
		logic [COUNT_W-1:0]      debounce_ticks;
		logic [KEYMAP_LOW_W-1:0] keymap_low;
		logic [CODE_W-1:0]       keymap_last;
	} mks_cfg_t;

	typedef struct packed {
		logic [COL_W-1:0]   column;
		phase_t             phase;
		logic [ROW_W-1:0]   row;
		logic [COUNT_W-1:0] count;
	} mks_state_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] column_drive;
		logic               key_valid;
		logic [CODE_W-1:0]  key_code;
		logic               scan_empty;
	} mks_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/mks_step.sv @@
// ----------------------------------------------------------------------------
// mks_step: one scan tick of the keypad scanner
// Takes the current scan state and one sample of the row pins, and gives the
// next scan state and the result of the tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mks_step
	import mks_pkg::*;
#(
	parameter int ROW_COUNT    = ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
	input  wire mks_state_t         cur,
	input  wire logic [LEVEL_W-1:0] levels,
	input  wire mks_cfg_t           cfg,
	output mks_state_t              nxt,
	output mks_result_t             res
);

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMN_COUNT - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROW_COUNT - 1);

	logic [COL_W-1:0]   col;
	logic [ROW_W-1:0]   row;
	logic [LEVEL_W-1:0] row_low;
	logic               held_hit;
	logic [ROW_W-1:0]   held_row;
	logic               scan_hit;
	logic [ROW_W-1:0]   scan_row;
	logic               wrap;
	logic [COL_W-1:0]   next_col;
	logic [COUNT_W-1:0] cnt_dec;

	// look up the code of the key at row r, column c
	function automatic logic [CODE_W-1:0] key_code_of(
		input mks_cfg_t         map,
		input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c
	);
		logic [POS_W-1:0]  pos;
		logic [CODE_W-1:0] code;
		pos = POS_W'(POS_W'(r) * POS_W'(COLUMN_COUNT)) + POS_W'(c);
		if (pos == POS_LAST) begin
			code = map.keymap_last;
		end else if (pos < POS_LAST) begin
			code = map.keymap_low[pos[2:0]*CODE_W +: CODE_W];
		end else begin
			code = '0;
		end
		return code;
	endfunction

	// clamp stray column and row values, mark pressed rows
	always_comb begin
		col = (cur.column > LAST_COL) ? '0 : cur.column;
		row = (cur.row > LAST_ROW) ? '0 : cur.row;
		for (int r = 0; r < LEVEL_W; r++) begin
			row_low[r] = (r < ROW_COUNT) && !levels[r];
		end
		wrap     = (col == LAST_COL);
		next_col = wrap ? '0 : COL_W'(col + 1'b1);
		cnt_dec  = (cur.count != '0) ? COUNT_W'(cur.count - 1'b1) : '0;
	end

	// find the first pressed row from row 0 and from the pending row
	always_comb begin
		held_hit = 1'b0;
		held_row = '0;
		scan_hit = 1'b0;
		scan_row = '0;
		for (int r = ROW_COUNT - 1; r >= 0; r--) begin
			if (row_low[r]) begin
				held_hit = 1'b1;
				held_row = ROW_W'(r);
				if (ROW_W'(r) >= row) begin
					scan_hit = 1'b1;
					scan_row = ROW_W'(r);
				end
			end
		end
	end

	// advance the scan
	always_comb begin
		nxt            = cur;
		nxt.column     = col;
		nxt.row        = row;
		res.key_valid  = 1'b0;
		res.key_code   = '0;
		res.scan_empty = 1'b0;

		if (cfg.report_mode) begin
			nxt.phase = PH_SCAN;
			if (held_hit) begin
				res.key_valid = 1'b1;
				res.key_code  = key_code_of(cfg, held_row, col);
				nxt.column    = '0;
				nxt.row       = '0;
			end else begin
				nxt.column     = next_col;
				nxt.row        = '0;
				res.scan_empty = wrap;
			end
		end else begin
			case (cur.phase)
				PH_DEBOUNCE: begin
					nxt.count = cnt_dec;
					if (cnt_dec == '0) begin
						if (row_low[row]) begin
							nxt.phase = PH_RELEASE;
						end else if (row != LAST_ROW) begin
							nxt.row   = ROW_W'(row + 1'b1);
							nxt.phase = PH_SCAN;
						end else begin
							nxt.column     = next_col;
							nxt.row        = '0;
							nxt.phase      = PH_SCAN;
							res.scan_empty = wrap;
						end
					end
				end
				PH_RELEASE: begin
					if (!row_low[row]) begin
						res.key_valid = 1'b1;
						res.key_code  = key_code_of(cfg, row, col);
						nxt.column    = '0;
						nxt.row       = '0;
						nxt.phase     = PH_SCAN;
					end
				end
				default: begin
					nxt.phase = PH_SCAN;
					if (scan_hit) begin
						nxt.row   = scan_row;
						nxt.count = cfg.debounce_ticks;
						nxt.phase = PH_DEBOUNCE;
					end else begin
						nxt.column     = next_col;
						nxt.row        = '0;
						res.scan_empty = wrap;
					end
				end
			endcase
		end

		res.column_drive = ~(DRIVE_W'(1) << nxt.column);
	end

endmodule

`default_nettype wire

@@ hw/rtl/matrix_keypad_scanner.sv @@
// A request is held in the input register, stepped, and its result held in the result register.
// Throughput: one request per cycle while the result channel does not stall.
// A request is held back only while the result register is full and stalled.
// Reset: scan restarts at column 0, row 0; debounce length returns to 20
// ticks, held mode off, key map cleared. No clearing pass.
// ----------------------------------------------------------------------------
// matrix_keypad_scanner: 3x3 key matrix scanner with debounce
// Registers the row sample, steps the scan state once per request and
// registers the column drive, key report and empty-scan flag.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_keypad_scanner
	import mks_pkg::*;
#(
	parameter int ROW_COUNT    = ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [LEVEL_W-1:0]     row_levels,

	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [DRIVE_W-1:0]          column_drive,
	output logic                        key_valid,
	output logic [CODE_W-1:0]           key_code,
	output logic                        scan_empty,

	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	mks_cfg_t           cfg_q;
	mks_state_t         state_q;
	mks_state_t         state_nxt;
	mks_result_t        res;
	mks_result_t        res_s2;
	logic               valid_s1;
	logic [LEVEL_W-1:0] levels_s1;
	logic               valid_s2;
	logic               adv2;
	logic               adv1;

	// flow control: the result register loads when empty or drained
	assign adv2      = !valid_s2 || !out_stall;
	assign adv1      = valid_s1 && adv2;
	assign in_stall  = valid_s1 && !adv2;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.report_mode    <= 1'b0;
			cfg_q.debounce_ticks <= DEBOUNCE_TICKS_RST;
			cfg_q.keymap_low     <= '0;
			cfg_q.keymap_last    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_REPORT_MODE:    cfg_q.report_mode    <= cfg_data[0];
				REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data[COUNT_W-1:0];
				REG_KEYMAP_LOW:     cfg_q.keymap_low     <= cfg_data[KEYMAP_LOW_W-1:0];
				REG_KEYMAP_LAST:    cfg_q.keymap_last    <= cfg_data[CODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register: hold the row sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			levels_s1 <= row_levels;
		end
	end

	// scan step
	mks_step #(
		.ROW_COUNT    (ROW_COUNT),
		.COLUMN_COUNT (COLUMN_COUNT)
	) u_step (
		.cur    (state_q),
		.levels (levels_s1),
		.cfg    (cfg_q),
		.nxt    (state_nxt),
		.res    (res)
	);

	// scan state: advance once per processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.column <= '0;
			state_q.phase  <= PH_SCAN;
			state_q.row    <= '0;
			state_q.count  <= '0;
		end else if (adv1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign column_drive = res_s2.column_drive;
	assign key_valid    = res_s2.key_valid;
	assign key_code     = res_s2.key_code;
	assign scan_empty   = res_s2.scan_empty;

	// a report is never also an empty scan
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(key_valid && scan_empty))
		else $error("key report and empty scan in one result");

	// no code without a report
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !key_valid) |-> (key_code == '0))
		else $error("key code set without a report");

	// exactly one column driven low
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($countones(~column_drive) == 1))
		else $error("column drive not one-cold");

	// a report restarts the scan at the first column and row
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && res.key_valid) |=> (state_q.column == '0 && state_q.row == '0))
		else $error("scan not restarted after a report");

	// stall only while the input register holds a waiting request
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

@@ sim/matrix_keypad_scanner_checker.sv @@
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_checker: scoreboard for the keypad scanner
// Watches the request, result and register channels, steps its own copy of
// the scan state for every accepted request, and compares each accepted
// result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_keypad_scanner_checker
	import mks_pkg::*;
#(
	parameter int ROW_COUNT    = ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   in_valid,
	input  wire logic                   in_stall,
	input  wire logic [LEVEL_W-1:0]     row_levels,

	input  wire logic                   out_valid,
	input  wire logic                   out_stall,
	input  wire logic [DRIVE_W-1:0]     column_drive,
	input  wire logic                   key_valid,
	input  wire logic [CODE_W-1:0]      key_code,
	input  wire logic                   scan_empty,

	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,

	output int                          fail_count,
	output int                          requests_seen,
	output int                          results_seen,
	output int                          reports_due,
	output int                          empties_due
);

	mks_cfg_t    cfg_copy;
	mks_state_t  scan;
	mks_result_t results_due[$];
	mks_result_t due;
	mks_result_t seen;
	mks_result_t next_due;
	int          fails;
	int          n_requests;
	int          n_results;
	int          n_reports;
	int          n_empties;

	// look up the code of the key at a matrix position, row major
	function automatic logic [CODE_W-1:0] mapped_code(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [POS_W-1:0] pos;
		pos = POS_W'(row * COLUMN_COUNT + col);
		if (pos < POS_LAST) begin
			return cfg_copy.keymap_low[CODE_W*pos +: CODE_W];
		end
		if (pos == POS_LAST) begin
			return cfg_copy.keymap_last;
		end
		return '0;
	endfunction

	// move to the next column from its first row; flag a wrap to column 0
	function automatic logic advance_column();
		scan.row   = '0;
		scan.phase = PH_SCAN;
		if (scan.column + 1 >= COLUMN_COUNT) begin
			scan.column = '0;
			return 1'b1;
		end
		scan.column = scan.column + 1'b1;
		return 1'b0;
	endfunction

	// step the scan state by one tick and form the result it gives
	task automatic scan_tick(input logic [LEVEL_W-1:0] levels, output mks_result_t res);
		logic found;
		res   = '0;
		found = 1'b0;
		if (scan.column >= COLUMN_COUNT) begin
			scan.column = '0;
		end
		if (scan.row >= ROW_COUNT) begin
			scan.row = '0;
		end

		if (cfg_copy.report_mode) begin
			// held mode: report the first low row of this column at once
			scan.phase = PH_SCAN;
			for (int r = 0; r < ROW_COUNT; r++) begin
				if (!found && !levels[r]) begin
					res.key_valid = 1'b1;
					res.key_code  = mapped_code(ROW_W'(r), scan.column);
					found         = 1'b1;
				end
			end
			if (found) begin
				scan.column = '0;
				scan.row    = '0;
			end else begin
				res.scan_empty = advance_column();
			end
		end else if (scan.phase == PH_DEBOUNCE) begin
			// count down, then confirm the row or drop it as a bounce
			if (scan.count != 0) begin
				scan.count = scan.count - 1'b1;
			end
			if (scan.count == 0) begin
				if (!levels[scan.row]) begin
					scan.phase = PH_RELEASE;
				end else if (scan.row + 1 < ROW_COUNT) begin
					scan.row   = scan.row + 1'b1;
					scan.phase = PH_SCAN;
				end else begin
					res.scan_empty = advance_column();
				end
			end
		end else if (scan.phase == PH_RELEASE) begin
			// report on release and restart the scan
			if (levels[scan.row]) begin
				res.key_valid = 1'b1;
				res.key_code  = mapped_code(scan.row, scan.column);
				scan.column   = '0;
				scan.row      = '0;
				scan.phase    = PH_SCAN;
			end
		end else begin
			// scan the rest of the column for a low row to debounce
			scan.phase = PH_SCAN;
			for (int r = 0; r < ROW_COUNT; r++) begin
				if (!found && r >= scan.row && !levels[r]) begin
					scan.row   = ROW_W'(r);
					scan.count = cfg_copy.debounce_ticks;
					scan.phase = PH_DEBOUNCE;
					found      = 1'b1;
				end
			end
			if (!found) begin
				res.scan_empty = advance_column();
			end
		end

		res.column_drive = ~(DRIVE_W'(1) << scan.column);
	endtask

	// report one field that differs and count it
	function automatic int field_differs(input string name, input logic [CODE_W-1:0] want,
			input logic [CODE_W-1:0] got);
		if (got !== want) begin
			$error("%s expected %0h got %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// track registers, check results, predict requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_copy.report_mode    = 1'b0;
			cfg_copy.debounce_ticks = DEBOUNCE_TICKS_RST;
			cfg_copy.keymap_low     = '0;
			cfg_copy.keymap_last    = '0;
			scan.column             = '0;
			scan.phase              = PH_SCAN;
			scan.row                = '0;
			scan.count              = '0;
			results_due.delete();
			fails         = 0;
			n_requests    = 0;
			n_results     = 0;
			n_reports     = 0;
			n_empties     = 0;
			fail_count    <= 0;
			requests_seen <= 0;
			results_seen  <= 0;
			reports_due   <= 0;
			empties_due   <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_REPORT_MODE: cfg_copy.report_mode = cfg_data[0];
					REG_DEBOUNCE_TICKS: cfg_copy.debounce_ticks = cfg_data[COUNT_W-1:0];
					REG_KEYMAP_LOW: cfg_copy.keymap_low = cfg_data[KEYMAP_LOW_W-1:0];
					REG_KEYMAP_LAST: cfg_copy.keymap_last = cfg_data[CODE_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				n_results++;
				seen = {column_drive, key_valid, key_code, scan_empty};
				if (results_due.size() == 0) begin
					$error("result with no request waiting: drive %0h valid %0b code %0h empty %0b",
						column_drive, key_valid, key_code, scan_empty);
					fails++;
				end else begin
					due = results_due.pop_front();
					fails += field_differs("column_drive", CODE_W'(due.column_drive),
						CODE_W'(seen.column_drive));
					fails += field_differs("key_valid", CODE_W'(due.key_valid),
						CODE_W'(seen.key_valid));
					fails += field_differs("key_code", due.key_code, seen.key_code);
					fails += field_differs("scan_empty", CODE_W'(due.scan_empty),
						CODE_W'(seen.scan_empty));
				end
			end

			if (in_valid && !in_stall) begin
				n_requests++;
				scan_tick(row_levels, next_due);
				if (next_due.key_valid) begin
					n_reports++;
				end
				if (next_due.scan_empty) begin
					n_empties++;
				end
				results_due.push_back(next_due);
			end

			fail_count    <= fails;
			requests_seen <= n_requests;
			results_seen  <= n_results;
			reports_due   <= n_reports;
			empties_due   <= n_empties;
		end
	end

endmodule

`default_nettype wire

@@ sim/tb_matrix_keypad_scanner.sv @@
// ----------------------------------------------------------------------------
// tb_matrix_keypad_scanner: testbench of the 3x3 keypad scanner
// Drives row samples as key presses with bounce, noise and idle scans
// through several register settings, with random gaps on both channels;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix_keypad_scanner;
	import mks_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int LONG_DEBOUNCE  = 65535;
	localparam int LONG_PRESS     = 40;
	localparam logic [LEVEL_W-1:0] ROWS_RELEASED = '1;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   in_valid     = 1'b0;
	logic                   in_stall;
	logic [LEVEL_W-1:0]     row_levels   = '1;
	logic                   out_valid;
	logic                   out_stall    = 1'b0;
	logic [DRIVE_W-1:0]     column_drive;
	logic                   key_valid;
	logic [CODE_W-1:0]      key_code;
	logic                   scan_empty;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	int   fail_count;
	int   requests_seen;
	int   results_seen;
	int   reports_due;
	int   empties_due;

	logic                   quiet        = 1'b0;
	logic                   cur_mode     = 1'b0;
	logic [COUNT_W-1:0]     cur_ticks    = DEBOUNCE_TICKS_RST;
	int                     items_sent   = 0;
	int                     settings_run = 0;
	int                     stall_left   = 0;
	int                     stall_roll;
	int                     idle_cycles  = 0;

	always #(HALF_PERIOD) clk = ~clk;

	matrix_keypad_scanner uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.row_levels   (row_levels),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.column_drive (column_drive),
		.key_valid    (key_valid),
		.key_code     (key_code),
		.scan_empty   (scan_empty),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	matrix_keypad_scanner_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.row_levels    (row_levels),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.column_drive  (column_drive),
		.key_valid     (key_valid),
		.key_code      (key_code),
		.scan_empty    (scan_empty),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.requests_seen (requests_seen),
		.results_seen  (results_seen),
		.reports_due   (reports_due),
		.empties_due   (empties_due)
	);

	// stall the result channel: mostly short stalls, a few long ones
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (quiet || stall_roll < 65) begin
				out_stall <= 1'b0;
			end else if (stall_roll < 95) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(8, 40);
			end
		end
	end

	// end the run when no channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_matrix_keypad_scanner NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// pick a request gap: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 60) begin
			return 0;
		end
		if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// offer one row sample and hold it until accepted
	task automatic send_levels(input logic [LEVEL_W-1:0] levels);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		row_levels <= levels;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_run(input logic [LEVEL_W-1:0] levels, input int count);
		repeat (count) send_levels(levels);
	endtask

	// drop the request valid and wait for every predicted result
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (requests_seen != results_seen) @(posedge clk);
	endtask

	// raise one register write and hold it until taken
	task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// write all registers while the block is idle
	task automatic apply_setting(input logic mode, input logic [COUNT_W-1:0] ticks,
			input logic [KEYMAP_LOW_W-1:0] low_codes, input logic [CODE_W-1:0] last_code);
		wait_drained();
		write_reg(REG_REPORT_MODE, CFG_DATA_W'(mode));
		write_reg(REG_DEBOUNCE_TICKS, CFG_DATA_W'(ticks));
		write_reg(REG_KEYMAP_LOW, CFG_DATA_W'(low_codes));
		write_reg(REG_KEYMAP_LAST, CFG_DATA_W'(last_code));
		cfg_valid <= 1'b0;
		cur_mode  = mode;
		cur_ticks = ticks;
		settings_run++;
	endtask

	function automatic logic [KEYMAP_LOW_W-1:0] random_keymap();
		return {$urandom, $urandom};
	endfunction

	// random presses, noise, idle scans and drain pauses
	task automatic run_phase(input int count);
		int stop_at;
		int kind;
		int hold;
		logic [LEVEL_W-1:0] pressed;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			quiet <= ($urandom_range(0, 9) == 0);
			kind  = $urandom_range(0, 99);
			if (kind < 60) begin
				// press one or more rows, maybe with contact bounce first
				pressed = ~LEVEL_W'($urandom_range(1, 7));
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 4)) send_levels(LEVEL_W'($urandom));
				end
				if (cur_mode) begin
					hold = $urandom_range(1, 3);
				end else begin
					hold = $urandom_range(1, int'(cur_ticks) + 4);
				end
				send_run(pressed, hold);
				send_run(ROWS_RELEASED, $urandom_range(1, 6));
			end else if (kind < 75) begin
				send_run(ROWS_RELEASED, $urandom_range(3, 9));
			end else if (kind < 96) begin
				repeat ($urandom_range(1, 5)) send_levels(LEVEL_W'($urandom));
			end else begin
				wait_drained();
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty scan, debounced presses on first and last row,
		// a bounce, all rows low, then held reports up to the last position
		apply_setting(1'b0, 16'd2, 64'h8877_6655_4433_2211, 8'h99);
		send_run(ROWS_RELEASED, 3);
		send_run(3'b110, 4);
		send_run(ROWS_RELEASED, 2);
		send_run(3'b011, 4);
		send_run(ROWS_RELEASED, 2);
		send_run(3'b110, 1);
		send_run(ROWS_RELEASED, 3);
		send_run(3'b000, 4);
		send_run(ROWS_RELEASED, 1);
		apply_setting(1'b1, 16'd2, 64'h8877_6655_4433_2211, 8'h99);
		send_run(3'b101, 1);
		send_run(ROWS_RELEASED, 2);
		send_run(3'b011, 1);
		send_run(3'b000, 1);

		// random phases across modes, debounce lengths and key maps
		apply_setting(1'b0, 16'd0, random_keymap(), CODE_W'($urandom));
		run_phase(150);
		apply_setting(1'b0, 16'd1, '0, '0);
		run_phase(150);
		apply_setting(1'b1, COUNT_W'($urandom), '1, '1);
		run_phase(150);
		apply_setting(1'b0, COUNT_W'($urandom_range(2, 10)), random_keymap(),
			CODE_W'($urandom));
		run_phase(200);

		// longest debounce: a steady press that leaves the count running,
		// then held mode takes over from the pending debounce
		apply_setting(1'b0, COUNT_W'(LONG_DEBOUNCE), random_keymap(), CODE_W'($urandom));
		quiet <= 1'b1;
		send_run(3'b101, LONG_PRESS);
		send_run(ROWS_RELEASED, 3);

		apply_setting(1'b1, COUNT_W'($urandom_range(0, 5)), random_keymap(),
			CODE_W'($urandom));
		run_phase(100);
		apply_setting(1'b0, COUNT_W'($urandom_range(3, 12)), random_keymap(),
			CODE_W'($urandom));
		run_phase(200);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d requests in %0d register settings: %0d key reports, %0d empty scans",
			requests_seen, settings_run, reports_due, empties_due);
		$display("held and debounced modes, debounce 0, 1, short and 65535, zero, full and random key maps");
		if (fail_count == 0 && requests_seen == results_seen) begin
			$display("tb_matrix_keypad_scanner OK");
		end else begin
			$display("tb_matrix_keypad_scanner NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/mks_pkg.sv
hw/rtl/mks_step.sv
hw/rtl/matrix_keypad_scanner.sv
sim/matrix_keypad_scanner_checker.sv
sim/tb_matrix_keypad_scanner.sv
